// File: design/lip_pkg.sv
`default_nettype none
package lip_pkg;

	// Per-item flags that ride alongside the divider stages.
	typedef struct packed {
		logic par;   // determinant is zero
		logic neg_x; // x quotient is negative
		logic neg_y; // y quotient is negative
		logic ovf_x; // x quotient known to overflow before division
		logic ovf_y; // y quotient known to overflow before division
	} flag_t;

endpackage
`default_nettype wire

// File: design/line_intersection_point_top.sv
// Pipeline: stages 1 to 7, the divider entry (stage 8), the divider stages, then the output register.
// Throughput: one beat per cycle; every stage advances together whenever the
// output register is empty or being taken, so a stall freezes the whole pipe.
// The divider is one restoring step per stage, COORD_WIDTH + 1 stages per quotient.
// Reset (arst_n low, asynchronous) clears every valid bit; payload is not reset.
`default_nettype none
module line_intersection_point_top #(
	parameter int COORD_WIDTH = 24
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [COORD_WIDTH-1:0] line_a_start_x,
	input  wire logic signed [COORD_WIDTH-1:0] line_a_start_y,
	input  wire logic signed [COORD_WIDTH-1:0] line_a_end_x,
	input  wire logic signed [COORD_WIDTH-1:0] line_a_end_y,
	input  wire logic signed [COORD_WIDTH-1:0] line_b_start_x,
	input  wire logic signed [COORD_WIDTH-1:0] line_b_start_y,
	input  wire logic signed [COORD_WIDTH-1:0] line_b_end_x,
	input  wire logic signed [COORD_WIDTH-1:0] line_b_end_y,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0]      cross_x,
	output logic signed [COORD_WIDTH-1:0]      cross_y,
	output logic                               parallel,
	output logic                               saturated
);

	localparam int W   = COORD_WIDTH;
	localparam int AW  = W + 1;         // line a/b coefficient
	localparam int CW  = 2 * W + 2;     // line c coefficient
	localparam int DW  = 2 * W + 3;     // determinant
	localparam int PBW = 3 * W + 3;     // b*c style product
	localparam int NW  = 3 * W + 4;     // numerator
	localparam int QW  = W + 1;         // quotient bits produced by the divider
	localparam int NS  = QW;            // divider stages

	// Global advance: the whole pipe moves when the output slot frees up.
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// ---------------------------------------------------------------- stage 1
	// Coefficients a = dy, b = -dx; hold the start points for c.
	logic              v_s1;
	logic signed [AW-1:0] a1_s1, b1_s1, a2_s1, b2_s1;
	logic signed [W-1:0]  ax_s1, ay_s1, bx_s1, by_s1;

	// ---------------------------------------------------------------- stage 2
	// All first-level products.
	logic              v_s2;
	logic signed [2*W:0]   pc1a_s2, pc1b_s2, pc2a_s2, pc2b_s2;
	logic signed [2*W+1:0] pd1_s2, pd2_s2;
	logic signed [AW-1:0]  a1_s2, b1_s2, a2_s2, b2_s2;
	logic signed [W-1:0]   bx_s2, by_s2;

	// ---------------------------------------------------------------- stage 3
	logic              v_s3;
	logic signed [CW-1:0] c1_s3, c2_s3;
	logic signed [DW-1:0] det_s3;
	logic signed [AW-1:0] a1_s3, b1_s3, a2_s3, b2_s3;
	logic signed [W-1:0]  bx_s3, by_s3;

	// ---------------------------------------------------------------- stage 4
	// Coefficient times c, split into high (signed) and low (unsigned) halves of c.
	logic              v_s4;
	logic signed [2*W+2:0] p_b2c1_h_s4, p_b2c1_l_s4, p_b1c2_h_s4, p_b1c2_l_s4;
	logic signed [2*W+2:0] p_a1c2_h_s4, p_a1c2_l_s4, p_a2c1_h_s4, p_a2c1_l_s4;
	logic signed [DW-1:0]  det_s4;
	logic signed [W-1:0]   bx_s4, by_s4;

	// ---------------------------------------------------------------- stage 5
	logic              v_s5;
	logic signed [PBW-1:0] b2c1_s5, b1c2_s5, a1c2_s5, a2c1_s5;
	logic signed [DW-1:0]  det_s5;
	logic signed [W-1:0]   bx_s5, by_s5;

	// ---------------------------------------------------------------- stage 6
	logic              v_s6;
	logic signed [NW-1:0] nx_s6, ny_s6;
	logic signed [DW-1:0] det_s6;
	logic signed [W-1:0]  bx_s6, by_s6;

	// ---------------------------------------------------------------- stage 7
	// Magnitudes and signs.
	logic              v_s7;
	logic [NW-1:0]     nxm_s7, nym_s7;
	logic [DW-1:0]     dm_s7;
	lip_pkg::flag_t    fl_s7;
	logic signed [W-1:0] bx_s7, by_s7;

	// ---------------------------------------------------------------- stage 8
	// Early overflow check and divider entry (array index 0).
	logic           v_sd  [NS+1];
	logic [DW-1:0]  rx_sd [NS+1];
	logic [DW-1:0]  ry_sd [NS+1];
	logic [QW-1:0]  qx_sd [NS+1];
	logic [QW-1:0]  qy_sd [NS+1];
	logic [QW-1:0]  lx_sd [NS+1];
	logic [QW-1:0]  ly_sd [NS+1];
	logic [DW-1:0]  d_sd  [NS+1];
	lip_pkg::flag_t fl_sd [NS+1];
	logic signed [W-1:0] bx_sd [NS+1];
	logic signed [W-1:0] by_sd [NS+1];

	// Valid chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_sd[0] <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_sd[0] <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1
			a1_s1 <= AW'(line_a_end_y) - AW'(line_a_start_y);
			b1_s1 <= AW'(line_a_start_x) - AW'(line_a_end_x);
			a2_s1 <= AW'(line_b_end_y) - AW'(line_b_start_y);
			b2_s1 <= AW'(line_b_start_x) - AW'(line_b_end_x);
			ax_s1 <= line_a_start_x;
			ay_s1 <= line_a_start_y;
			bx_s1 <= line_b_start_x;
			by_s1 <= line_b_start_y;
			// stage 2
			pc1a_s2 <= a1_s1 * ax_s1;
			pc1b_s2 <= b1_s1 * ay_s1;
			pc2a_s2 <= a2_s1 * bx_s1;
			pc2b_s2 <= b2_s1 * by_s1;
			pd1_s2  <= a1_s1 * b2_s1;
			pd2_s2  <= a2_s1 * b1_s1;
			a1_s2 <= a1_s1;
			b1_s2 <= b1_s1;
			a2_s2 <= a2_s1;
			b2_s2 <= b2_s1;
			bx_s2 <= bx_s1;
			by_s2 <= by_s1;
			// stage 3
			c1_s3  <= CW'(pc1a_s2) + CW'(pc1b_s2);
			c2_s3  <= CW'(pc2a_s2) + CW'(pc2b_s2);
			det_s3 <= DW'(pd1_s2) - DW'(pd2_s2);
			a1_s3 <= a1_s2;
			b1_s3 <= b1_s2;
			a2_s3 <= a2_s2;
			b2_s3 <= b2_s2;
			bx_s3 <= bx_s2;
			by_s3 <= by_s2;
			// stage 4
			p_b2c1_h_s4 <= b2_s3 * $signed(c1_s3[CW-1:W+1]);
			p_b2c1_l_s4 <= b2_s3 * $signed({1'b0, c1_s3[W:0]});
			p_b1c2_h_s4 <= b1_s3 * $signed(c2_s3[CW-1:W+1]);
			p_b1c2_l_s4 <= b1_s3 * $signed({1'b0, c2_s3[W:0]});
			p_a1c2_h_s4 <= a1_s3 * $signed(c2_s3[CW-1:W+1]);
			p_a1c2_l_s4 <= a1_s3 * $signed({1'b0, c2_s3[W:0]});
			p_a2c1_h_s4 <= a2_s3 * $signed(c1_s3[CW-1:W+1]);
			p_a2c1_l_s4 <= a2_s3 * $signed({1'b0, c1_s3[W:0]});
			det_s4 <= det_s3;
			bx_s4  <= bx_s3;
			by_s4  <= by_s3;
			// stage 5: recombine the halves
			b2c1_s5 <= $signed({p_b2c1_h_s4[2*W+1:0], {(W+1){1'b0}}}) + PBW'(p_b2c1_l_s4);
			b1c2_s5 <= $signed({p_b1c2_h_s4[2*W+1:0], {(W+1){1'b0}}}) + PBW'(p_b1c2_l_s4);
			a1c2_s5 <= $signed({p_a1c2_h_s4[2*W+1:0], {(W+1){1'b0}}}) + PBW'(p_a1c2_l_s4);
			a2c1_s5 <= $signed({p_a2c1_h_s4[2*W+1:0], {(W+1){1'b0}}}) + PBW'(p_a2c1_l_s4);
			det_s5 <= det_s4;
			bx_s5  <= bx_s4;
			by_s5  <= by_s4;
			// stage 6
			nx_s6  <= NW'(b2c1_s5) - NW'(b1c2_s5);
			ny_s6  <= NW'(a1c2_s5) - NW'(a2c1_s5);
			det_s6 <= det_s5;
			bx_s6  <= bx_s5;
			by_s6  <= by_s5;
			// stage 7
			nxm_s7 <= nx_s6[NW-1] ? NW'(-nx_s6) : NW'(nx_s6);
			nym_s7 <= ny_s6[NW-1] ? NW'(-ny_s6) : NW'(ny_s6);
			dm_s7  <= det_s6[DW-1] ? DW'(-det_s6) : DW'(det_s6);
			fl_s7.par   <= (det_s6 == '0);
			fl_s7.neg_x <= nx_s6[NW-1] ^ det_s6[DW-1];
			fl_s7.neg_y <= ny_s6[NW-1] ^ det_s6[DW-1];
			fl_s7.ovf_x <= 1'b0;
			fl_s7.ovf_y <= 1'b0;
			bx_s7 <= bx_s6;
			by_s7 <= by_s6;
			// stage 8: quotient >= 2^QW overflows at once; else the top part is the
			// first partial remainder
			rx_sd[0] <= nxm_s7[NW-1:QW];
			ry_sd[0] <= nym_s7[NW-1:QW];
			lx_sd[0] <= nxm_s7[QW-1:0];
			ly_sd[0] <= nym_s7[QW-1:0];
			qx_sd[0] <= '0;
			qy_sd[0] <= '0;
			d_sd[0]  <= dm_s7;
			fl_sd[0].par   <= fl_s7.par;
			fl_sd[0].neg_x <= fl_s7.neg_x;
			fl_sd[0].neg_y <= fl_s7.neg_y;
			fl_sd[0].ovf_x <= (nxm_s7[NW-1:QW] >= dm_s7);
			fl_sd[0].ovf_y <= (nym_s7[NW-1:QW] >= dm_s7);
			bx_sd[0] <= bx_s7;
			by_sd[0] <= by_s7;
		end
	end

	// Restoring divider: one quotient bit per stage, most significant first.
	for (genvar k = 0; k < NS; k++) begin : g_div
		localparam int J = QW - 1 - k;
		logic [DW:0] tx, ty;
		logic        gx, gy;

		always_comb begin
			tx = {rx_sd[k], lx_sd[k][J]};
			ty = {ry_sd[k], ly_sd[k][J]};
			gx = (tx >= {1'b0, d_sd[k]});
			gy = (ty >= {1'b0, d_sd[k]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[k+1] <= 1'b0;
			end else if (en) begin
				v_sd[k+1] <= v_sd[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rx_sd[k+1] <= gx ? DW'(tx - {1'b0, d_sd[k]}) : DW'(tx);
				ry_sd[k+1] <= gy ? DW'(ty - {1'b0, d_sd[k]}) : DW'(ty);
				qx_sd[k+1] <= qx_sd[k] | (QW'(gx) << J);
				qy_sd[k+1] <= qy_sd[k] | (QW'(gy) << J);
				lx_sd[k+1] <= lx_sd[k];
				ly_sd[k+1] <= ly_sd[k];
				d_sd[k+1]  <= d_sd[k];
				fl_sd[k+1] <= fl_sd[k];
				bx_sd[k+1] <= bx_sd[k];
				by_sd[k+1] <= by_sd[k];
			end
		end
	end

	// ---------------------------------------------------------------- output
	// Apply sign, clip to range, pick the fallback point for parallel lines.
	logic [QW-1:0]       lim_x, lim_y;
	logic                sat_x, sat_y;
	logic signed [W-1:0] res_x, res_y;
	lip_pkg::flag_t      fl_f;

	always_comb begin
		fl_f  = fl_sd[NS];
		lim_x = fl_f.neg_x ? (QW'(1) << (W - 1)) : ((QW'(1) << (W - 1)) - QW'(1));
		lim_y = fl_f.neg_y ? (QW'(1) << (W - 1)) : ((QW'(1) << (W - 1)) - QW'(1));
		sat_x = fl_f.ovf_x || (qx_sd[NS] > lim_x);
		sat_y = fl_f.ovf_y || (qy_sd[NS] > lim_y);
		if (sat_x) begin
			res_x = fl_f.neg_x ? W'(-lim_x) : W'(lim_x);
		end else begin
			res_x = fl_f.neg_x ? W'(-qx_sd[NS]) : W'(qx_sd[NS]);
		end
		if (sat_y) begin
			res_y = fl_f.neg_y ? W'(-lim_y) : W'(lim_y);
		end else begin
			res_y = fl_f.neg_y ? W'(-qy_sd[NS]) : W'(qy_sd[NS]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_sd[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cross_x   <= fl_f.par ? bx_sd[NS] : res_x;
			cross_y   <= fl_f.par ? by_sd[NS] : res_y;
			parallel  <= fl_f.par;
			saturated <= !fl_f.par && (sat_x || sat_y);
		end
	end

	// ---------------------------------------------------------------- checks
	a_par_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(parallel && saturated))
		else $error("parallel and saturated both set");

	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output slot");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ready && !in_valid) |=> !v_s1)
		else $error("beat created without input");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_sd[0]) && $stable(v_s1))
		else $error("pipeline moved during stall");

endmodule
`default_nettype wire
